@@ rtl/assert_macros.svh @@
// Assertion helpers used by the RTL file that carries checks.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ rtl/i2crm_pkg.sv @@
// Types and constants of the I2C register master.
// No dependencies; imported by i2crm_seq and i2c_register_master_top.
`default_nettype none

package i2crm_pkg;

    // Buffer and field sizes
    localparam int MAX_BYTES = 16;
    localparam int BUF_IDX_W = $clog2(MAX_BYTES);
    localparam int LEN_W     = 5;
    localparam int DELAY_W   = 10;   // holds 4 us at 255 ticks per us

    // Register reset values
    localparam logic [7:0] UNIT_TICKS_RST  = 8'd1;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    // Input word kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_BEGIN = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BUSY = 2'd1;
    localparam logic [1:0] STAT_NACK = 2'd2;

    // Bits of the latched flags
    localparam int FLAG_READ = 0;
    localparam int FLAG_SKIP = 1;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_UNIT_TICKS  = 1'b0,
        CFG_ACK_TIMEOUT = 1'b1
    } t_cfg_idx;

    // Bus sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_START_CHK  = 5'd1,
        PH_START_HOLD = 5'd2,
        PH_TX_SETUP   = 5'd3,
        PH_TX_HIGH    = 5'd4,
        PH_TX_LOW     = 5'd5,
        PH_ACKW_LOW   = 5'd6,
        PH_ACKW_HIGH  = 5'd7,
        PH_ACKW_POLL  = 5'd8,
        PH_RX_LOW     = 5'd9,
        PH_RX_HIGH    = 5'd10,
        PH_MACK_LOW   = 5'd11,
        PH_MACK_HIGH  = 5'd12,
        PH_MACK_END   = 5'd13,
        PH_STOP_LOW   = 5'd14,
        PH_STOP_HIGH  = 5'd15,
        PH_STOP_END   = 5'd16
    } t_phase;

    // Which byte of the transaction is on the bus
    typedef enum logic [1:0] {
        ST_ADDR_W = 2'd0,
        ST_REG    = 2'd1,
        ST_ADDR_R = 2'd2,
        ST_DATA   = 2'd3
    } t_stage;

    // Input word
    typedef struct packed {
        logic [1:0]       kind;
        logic             sda_sample;
        logic [6:0]       device_addr;
        logic [7:0]       reg_addr;
        logic             is_read;
        logic             skip_reg;
        logic [LEN_W-1:0] length;
        logic [3:0]       byte_index;
        logic [7:0]       write_byte;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       done_res;
        logic [1:0] status;
    } t_out_word;

endpackage

`default_nettype wire

@@ rtl/i2c_register_master_top.sv @@
// I2C register master: input register, sequencer step, result register.
// Accepted words pass the input register, then the result register.
// One word per cycle unless the output stalls; one sequencer phase step per word.
// Sync reset: sequencer idle, SCL/SDA released, unit_ticks 1, ack_timeout 250,
// both pipeline registers empty; the write-byte buffer is not cleared.
`default_nettype none
`include "assert_macros.svh"

module i2c_register_master_top import i2crm_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_word   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_word       o_out_data,
    input  wire logic       i_cfg_we,
    input  wire t_cfg_idx   i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);

    logic       r_in_vld;
    t_in_word   r_in_word;
    logic       r_out_vld;
    t_out_word  r_out_word;
    logic [7:0] r_unit_ticks;
    logic [7:0] r_ack_timeout;
    logic       w_adv;
    logic       w_in_acc;
    t_out_word  w_result;

    // Pipeline advances when the result register is free or being taken
    assign w_adv      = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks  <= UNIT_TICKS_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UNIT_TICKS:  r_unit_ticks  <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_word <= i_in_data;
        end
    end

    i2crm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_adv),
        .i_item        (r_in_word),
        .i_unit_ticks  (r_unit_ticks),
        .i_ack_timeout (r_ack_timeout),
        .o_result      (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_word;

    // Checks
    `ASSERT_NXT(a_adv_fills_out, w_adv, r_out_vld)
    `ASSERT_IMP(a_rx_while_busy, r_out_vld && r_out_word.rx_valid, r_out_word.busy_res)
    `ASSERT_IMP(a_last_has_rx, r_out_vld && r_out_word.rx_last, r_out_word.rx_valid)
    `ASSERT_IMP(a_done_released, r_out_vld && r_out_word.done_res,
                !r_out_word.busy_res && r_out_word.scl_level && r_out_word.sda_release)

endmodule

`default_nettype wire

@@ rtl/i2crm_seq.sv @@
// Bus sequencer: phase state machine, timing counters and write-byte buffer.
// Depends on i2crm_pkg; one step per word, result returned combinationally.
`default_nettype none

module i2crm_seq import i2crm_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_word  i_item,
    input  wire logic [7:0] i_unit_ticks,
    input  wire logic [7:0] i_ack_timeout,
    output t_out_word      o_result
);

    // State registers and next values
    t_phase               r_phase, n_phase;
    t_stage               r_stage, n_stage;
    logic [DELAY_W-1:0]   r_delay, n_delay;
    logic [3:0]           r_bit, n_bit;
    logic [7:0]           r_shift, n_shift;
    logic [LEN_W-1:0]     r_byte_cnt, n_byte_cnt;
    logic [7:0]           r_ack_wait, n_ack_wait;
    logic [6:0]           r_addr, n_addr;
    logic [7:0]           r_reg, n_reg;
    logic [1:0]           r_flags, n_flags;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [1:0]           r_status, n_status;
    logic                 r_scl, n_scl;
    logic                 r_sda, n_sda;

    // Write-byte buffer, undefined until loaded
    logic [7:0]           r_tx_buf [MAX_BYTES];

    // Phase lengths of 1, 2 and 4 us
    logic [DELAY_W-1:0]   w_d1, w_d2, w_d4;

    // Decision flags of one step
    logic                 v_ack, v_ack_ok, v_after_reg, v_write_next, v_send, v_stop;
    logic [7:0]           v_send_byte;
    logic                 v_rx, v_rx_last, v_done;
    logic [LEN_W:0]       v_next_cnt;

    assign w_d1 = (i_unit_ticks == 8'd0) ? DELAY_W'(1) : DELAY_W'(i_unit_ticks);
    assign w_d2 = w_d1 << 1;
    assign w_d4 = w_d1 << 2;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_stage    <= ST_ADDR_W;
            r_delay    <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_byte_cnt <= '0;
            r_ack_wait <= '0;
            r_addr     <= '0;
            r_reg      <= '0;
            r_flags    <= '0;
            r_len      <= '0;
            r_status   <= STAT_OK;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_stage    <= n_stage;
            r_delay    <= n_delay;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_byte_cnt <= n_byte_cnt;
            r_ack_wait <= n_ack_wait;
            r_addr     <= n_addr;
            r_reg      <= n_reg;
            r_flags    <= n_flags;
            r_len      <= n_len;
            r_status   <= n_status;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
        end
    end

    // Buffer load
    always_ff @(posedge i_clk) begin
        if (i_step && i_item.kind == KIND_LOAD) begin
            r_tx_buf[i_item.byte_index] <= i_item.write_byte;
        end
    end

    // Next state and result of one word
    always_comb begin
        n_phase      = r_phase;
        n_stage      = r_stage;
        n_delay      = r_delay;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_byte_cnt   = r_byte_cnt;
        n_ack_wait   = r_ack_wait;
        n_addr       = r_addr;
        n_reg        = r_reg;
        n_flags      = r_flags;
        n_len        = r_len;
        n_status     = r_status;
        n_scl        = r_scl;
        n_sda        = r_sda;
        v_ack        = 1'b0;
        v_ack_ok     = 1'b0;
        v_after_reg  = 1'b0;
        v_write_next = 1'b0;
        v_send       = 1'b0;
        v_send_byte  = '0;
        v_stop       = 1'b0;
        v_rx         = 1'b0;
        v_rx_last    = 1'b0;
        v_done       = 1'b0;
        v_next_cnt   = {1'b0, r_byte_cnt} + (LEN_W+1)'(1);

        case (i_item.kind)
            KIND_TICK: begin
                if (r_phase == PH_ACKW_POLL) begin
                    // poll SDA every tick until ACK or timeout
                    if (!i_item.sda_sample) begin
                        n_scl    = 1'b0;
                        v_ack    = 1'b1;
                        v_ack_ok = 1'b1;
                    end else if (r_ack_wait >= i_ack_timeout) begin
                        v_ack    = 1'b1;
                    end else begin
                        n_ack_wait = r_ack_wait + 8'd1;
                    end
                end else if (r_phase != PH_IDLE && r_delay > DELAY_W'(1)) begin
                    n_delay = r_delay - DELAY_W'(1);
                end else if (r_phase != PH_IDLE) begin
                    // end of a timed phase
                    case (r_phase)
                        PH_START_CHK: begin
                            if (r_stage == ST_ADDR_W && !i_item.sda_sample) begin
                                n_status = STAT_BUSY;
                                v_done   = 1'b1;
                                n_phase  = PH_IDLE;
                                n_delay  = '0;
                                n_scl    = 1'b1;
                                n_sda    = 1'b1;
                            end else begin
                                n_phase = PH_START_HOLD;
                                n_delay = w_d1;
                                n_scl   = 1'b1;
                                n_sda   = 1'b0;
                            end
                        end
                        PH_START_HOLD: begin
                            v_send      = 1'b1;
                            v_send_byte = {r_addr, r_stage == ST_ADDR_R};
                        end
                        PH_TX_SETUP: begin
                            n_phase = PH_TX_HIGH;
                            n_delay = w_d2;
                            n_scl   = 1'b1;
                        end
                        PH_TX_HIGH: begin
                            n_phase = PH_TX_LOW;
                            n_delay = w_d2;
                            n_scl   = 1'b0;
                        end
                        PH_TX_LOW: begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bit   = r_bit + 4'd1;
                            n_delay = (n_bit >= 4'd8) ? w_d1 : w_d2;
                            n_phase = (n_bit >= 4'd8) ? PH_ACKW_LOW : PH_TX_SETUP;
                            n_scl   = 1'b0;
                            n_sda   = (n_bit >= 4'd8) ? 1'b1 : r_shift[6];
                        end
                        PH_ACKW_LOW: begin
                            n_phase = PH_ACKW_HIGH;
                            n_delay = w_d1;
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                        end
                        PH_ACKW_HIGH: begin
                            n_ack_wait = '0;
                            n_phase    = PH_ACKW_POLL;
                            n_delay    = '0;
                        end
                        PH_RX_LOW: begin
                            n_phase = PH_RX_HIGH;
                            n_delay = w_d1;
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                        end
                        PH_RX_HIGH: begin
                            n_shift = {r_shift[6:0], i_item.sda_sample};
                            n_bit   = r_bit + 4'd1;
                            n_delay = w_d2;
                            n_scl   = 1'b0;
                            if (n_bit >= 4'd8) begin
                                // byte complete: ACK unless it is the last
                                v_rx      = 1'b1;
                                v_rx_last = v_next_cnt >= {1'b0, r_len};
                                n_phase   = PH_MACK_LOW;
                                n_sda     = v_rx_last;
                            end else begin
                                n_phase = PH_RX_LOW;
                                n_sda   = 1'b1;
                            end
                        end
                        PH_MACK_LOW: begin
                            n_phase = PH_MACK_HIGH;
                            n_delay = w_d2;
                            n_scl   = 1'b1;
                        end
                        PH_MACK_HIGH: begin
                            n_phase = PH_MACK_END;
                            n_delay = w_d2;
                            n_scl   = 1'b0;
                        end
                        PH_MACK_END: begin
                            n_byte_cnt = v_next_cnt[LEN_W-1:0];
                            n_bit      = '0;
                            n_shift    = '0;
                            if (n_byte_cnt < r_len) begin
                                n_phase = PH_RX_LOW;
                                n_delay = w_d2;
                                n_scl   = 1'b0;
                                n_sda   = 1'b1;
                            end else begin
                                v_stop = 1'b1;
                            end
                        end
                        PH_STOP_LOW: begin
                            n_phase = PH_STOP_HIGH;
                            n_delay = w_d1;
                            n_scl   = 1'b1;
                            n_sda   = 1'b0;
                        end
                        PH_STOP_HIGH: begin
                            n_phase = PH_STOP_END;
                            n_delay = w_d4;
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                        end
                        PH_STOP_END: begin
                            v_done  = 1'b1;
                            n_phase = PH_IDLE;
                            n_delay = '0;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            KIND_BEGIN: begin
                if (r_phase == PH_IDLE) begin
                    n_addr     = i_item.device_addr;
                    n_reg      = i_item.reg_addr;
                    n_flags    = {i_item.skip_reg, i_item.is_read};
                    n_len      = (i_item.length > LEN_W'(MAX_BYTES)) ?
                                 LEN_W'(MAX_BYTES) : i_item.length;
                    n_status   = STAT_OK;
                    n_byte_cnt = '0;
                    n_bit      = '0;
                    n_shift    = '0;
                    n_ack_wait = '0;
                    n_stage    = ST_ADDR_W;
                    n_phase    = PH_START_CHK;
                    n_delay    = w_d4;
                    n_scl      = 1'b1;
                    n_sda      = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Acknowledge outcome; a NACK on the register byte is ignored
        if (v_ack) begin
            if (r_stage == ST_REG) begin
                v_after_reg = 1'b1;
            end else if (!v_ack_ok) begin
                n_status = STAT_NACK;
                v_stop   = 1'b1;
            end else begin
                case (r_stage)
                    ST_ADDR_W: begin
                        if (r_flags[FLAG_SKIP]) begin
                            v_after_reg = 1'b1;
                        end else begin
                            n_stage     = ST_REG;
                            v_send      = 1'b1;
                            v_send_byte = r_reg;
                        end
                    end
                    ST_ADDR_R: begin
                        n_byte_cnt = '0;
                        if (r_len == '0) begin
                            v_stop = 1'b1;
                        end else begin
                            n_phase = PH_RX_LOW;
                            n_delay = w_d2;
                            n_scl   = 1'b0;
                            n_sda   = 1'b1;
                        end
                    end
                    default: begin
                        n_byte_cnt   = v_next_cnt[LEN_W-1:0];
                        v_write_next = 1'b1;
                    end
                endcase
            end
        end

        // After the register byte: repeated start for reads, data for writes
        if (v_after_reg) begin
            if (r_flags[FLAG_READ]) begin
                n_stage = ST_ADDR_R;
                n_phase = PH_START_CHK;
                n_delay = w_d4;
                n_scl   = 1'b1;
                n_sda   = 1'b1;
            end else begin
                n_byte_cnt   = '0;
                v_write_next = 1'b1;
            end
        end

        // Next data byte or stop
        if (v_write_next) begin
            if (n_byte_cnt < r_len) begin
                n_stage     = ST_DATA;
                v_send      = 1'b1;
                v_send_byte = r_tx_buf[n_byte_cnt[BUF_IDX_W-1:0]];
            end else begin
                v_stop = 1'b1;
            end
        end

        // Start shifting a byte out, MSB first
        if (v_send) begin
            n_shift = v_send_byte;
            n_bit   = '0;
            n_phase = PH_TX_SETUP;
            n_delay = w_d2;
            n_scl   = 1'b0;
            n_sda   = v_send_byte[7];
        end

        if (v_stop) begin
            n_phase = PH_STOP_LOW;
            n_delay = w_d1;
            n_scl   = 1'b0;
            n_sda   = 1'b0;
        end
    end

    // Result word
    always_comb begin
        o_result.scl_level   = n_scl;
        o_result.sda_release = n_sda;
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.rx_valid    = v_rx;
        o_result.rx_byte     = v_rx ? n_shift : 8'd0;
        o_result.rx_last     = v_rx_last;
        o_result.done_res    = v_done;
        o_result.status      = n_status;
    end

endmodule

`default_nettype wire

@@ tb/i2c_register_master_top_tb.sv @@
// Testbench for the I2C register master: runs directed and random bus transfers and
// checks every result word against a bit-level model of the sequencer.
// Depends on i2crm_pkg and i2c_register_master_top.
`default_nettype none

module i2c_register_master_top_tb;
    import i2crm_pkg::*;

    // Input word kind that the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Expected bus behavior and queue of predicted result words
    class i2c_word_scoreboard;
        logic [7:0]  unit_ticks;
        logic [7:0]  ack_timeout;
        t_phase      phase;
        t_stage      stage;
        logic [15:0] delay_count;
        logic [3:0]  bit_count;
        logic [7:0]  shift_reg;
        logic [4:0]  byte_count;
        logic [7:0]  ack_wait;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic        rd_flag;
        logic        skip_flag;
        logic [4:0]  xfer_len;
        logic [7:0]  tx_buf [MAX_BYTES];
        logic [1:0]  last_status;
        logic        scl;
        logic        sda;
        t_out_word   cur;
        t_out_word   expected_words[$];
        int          errors;

        function new();
            errors = 0;
            unit_ticks = UNIT_TICKS_RST;
            ack_timeout = ACK_TIMEOUT_RST;
            phase = PH_IDLE;
            stage = ST_ADDR_W;
            delay_count = '0;
            bit_count = '0;
            shift_reg = '0;
            byte_count = '0;
            ack_wait = '0;
            dev_addr = '0;
            reg_addr = '0;
            rd_flag = 1'b0;
            skip_flag = 1'b0;
            xfer_len = '0;
            last_status = STAT_OK;
            scl = 1'b1;
            sda = 1'b1;
            foreach (tx_buf[i]) tx_buf[i] = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [7:0] val);
            case (idx)
                CFG_UNIT_TICKS:  unit_ticks = val;
                CFG_ACK_TIMEOUT: ack_timeout = val;
                default: ;
            endcase
        endfunction

        // Enter a phase lasting us microseconds with the given line levels
        function void go_phase(t_phase ph, int us, logic c, logic d);
            logic [15:0] u;
            u = (unit_ticks == 8'd0) ? 16'd1 : {8'd0, unit_ticks};
            phase = ph;
            delay_count = 16'(us) * u;
            scl = c;
            sda = d;
        endfunction

        function void send_byte(logic [7:0] b);
            shift_reg = b;
            bit_count = '0;
            go_phase(PH_TX_SETUP, 2, 1'b0, b[7]);
        endfunction

        function void start_stop();
            go_phase(PH_STOP_LOW, 1, 1'b0, 1'b0);
        endfunction

        function void write_next();
            if (byte_count < xfer_len && byte_count < MAX_BYTES) begin
                stage = ST_DATA;
                send_byte(tx_buf[byte_count[3:0]]);
            end else begin
                start_stop();
            end
        endfunction

        function void after_register();
            if (rd_flag) begin
                stage = ST_ADDR_R;
                go_phase(PH_START_CHK, 4, 1'b1, 1'b1);
            end else begin
                byte_count = '0;
                write_next();
            end
        endfunction

        function void after_ack(bit ok);
            if (stage == ST_REG) begin
                // a refused register byte is not an error
                after_register();
                return;
            end
            if (!ok) begin
                last_status = STAT_NACK;
                start_stop();
                return;
            end
            case (stage)
                ST_ADDR_W: begin
                    if (skip_flag) begin
                        after_register();
                    end else begin
                        stage = ST_REG;
                        send_byte(reg_addr);
                    end
                end
                ST_ADDR_R: begin
                    byte_count = '0;
                    if (xfer_len == 0) start_stop();
                    else go_phase(PH_RX_LOW, 2, 1'b0, 1'b1);
                end
                default: begin
                    byte_count = byte_count + 1'b1;
                    write_next();
                end
            endcase
        endfunction

        function void end_of_phase(logic s);
            bit is_last;
            case (phase)
                PH_START_CHK: begin
                    // only the first start checks for a free bus
                    if (stage == ST_ADDR_W && s == 1'b0) begin
                        last_status = STAT_BUSY;
                        cur.done_res = 1'b1;
                        phase = PH_IDLE;
                        delay_count = '0;
                        scl = 1'b1;
                        sda = 1'b1;
                    end else begin
                        go_phase(PH_START_HOLD, 1, 1'b1, 1'b0);
                    end
                end
                PH_START_HOLD: send_byte({dev_addr, stage == ST_ADDR_R});
                PH_TX_SETUP:   go_phase(PH_TX_HIGH, 2, 1'b1, sda);
                PH_TX_HIGH:    go_phase(PH_TX_LOW, 2, 1'b0, sda);
                PH_TX_LOW: begin
                    shift_reg = shift_reg << 1;
                    bit_count = bit_count + 1'b1;
                    if (bit_count >= 8) go_phase(PH_ACKW_LOW, 1, 1'b0, 1'b1);
                    else go_phase(PH_TX_SETUP, 2, 1'b0, shift_reg[7]);
                end
                PH_ACKW_LOW: go_phase(PH_ACKW_HIGH, 1, 1'b1, 1'b1);
                PH_ACKW_HIGH: begin
                    ack_wait = '0;
                    phase = PH_ACKW_POLL;
                    delay_count = '0;
                end
                PH_RX_LOW: go_phase(PH_RX_HIGH, 1, 1'b1, 1'b1);
                PH_RX_HIGH: begin
                    shift_reg = {shift_reg[6:0], s};
                    bit_count = bit_count + 1'b1;
                    if (bit_count >= 8) begin
                        is_last = (int'(byte_count) + 1 >= int'(xfer_len));
                        cur.rx_valid = 1'b1;
                        cur.rx_byte = shift_reg;
                        cur.rx_last = is_last;
                        go_phase(PH_MACK_LOW, 2, 1'b0, is_last);
                    end else begin
                        go_phase(PH_RX_LOW, 2, 1'b0, 1'b1);
                    end
                end
                PH_MACK_LOW:  go_phase(PH_MACK_HIGH, 2, 1'b1, sda);
                PH_MACK_HIGH: go_phase(PH_MACK_END, 2, 1'b0, sda);
                PH_MACK_END: begin
                    byte_count = byte_count + 1'b1;
                    bit_count = '0;
                    shift_reg = '0;
                    if (byte_count < xfer_len) go_phase(PH_RX_LOW, 2, 1'b0, 1'b1);
                    else start_stop();
                end
                PH_STOP_LOW:  go_phase(PH_STOP_HIGH, 1, 1'b1, 1'b0);
                PH_STOP_HIGH: go_phase(PH_STOP_END, 4, 1'b1, 1'b1);
                PH_STOP_END: begin
                    cur.done_res = 1'b1;
                    phase = PH_IDLE;
                    delay_count = '0;
                end
                default: phase = PH_IDLE;
            endcase
        endfunction

        function void tick(logic s);
            if (phase == PH_IDLE) return;
            if (phase == PH_ACKW_POLL) begin
                if (s == 1'b0) begin
                    scl = 1'b0;
                    after_ack(1'b1);
                end else if (ack_wait >= ack_timeout) begin
                    after_ack(1'b0);
                end else begin
                    ack_wait = ack_wait + 1'b1;
                end
                return;
            end
            if (delay_count > 1) delay_count = delay_count - 1'b1;
            else end_of_phase(s);
        endfunction

        // Advance the bus sequencer by one input word and return its result word
        function t_out_word advance_bus(t_in_word w);
            cur = '0;
            case (w.kind)
                KIND_TICK: tick(w.sda_sample);
                KIND_BEGIN: begin
                    if (phase == PH_IDLE) begin
                        dev_addr = w.device_addr;
                        reg_addr = w.reg_addr;
                        rd_flag = w.is_read;
                        skip_flag = w.skip_reg;
                        xfer_len = (w.length > MAX_BYTES) ? 5'(MAX_BYTES) : w.length;
                        last_status = STAT_OK;
                        byte_count = '0;
                        bit_count = '0;
                        shift_reg = '0;
                        ack_wait = '0;
                        stage = ST_ADDR_W;
                        go_phase(PH_START_CHK, 4, 1'b1, 1'b1);
                    end
                end
                KIND_LOAD: tx_buf[w.byte_index] = w.write_byte;
                default: ;
            endcase
            cur.scl_level = scl;
            cur.sda_release = sda;
            cur.busy_res = (phase != PH_IDLE);
            cur.status = last_status;
            return cur;
        endfunction

        function void note_word(t_in_word w);
            expected_words.push_back(advance_bus(w));
        endfunction

        function void cmp(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            want = expected_words.pop_front();
            cmp("scl_level", want.scl_level, got.scl_level);
            cmp("sda_release", want.sda_release, got.sda_release);
            cmp("busy_res", want.busy_res, got.busy_res);
            cmp("rx_valid", want.rx_valid, got.rx_valid);
            cmp("rx_byte", want.rx_byte, got.rx_byte);
            cmp("rx_last", want.rx_last, got.rx_last);
            cmp("done_res", want.done_res, got.done_res);
            cmp("status", want.status, got.status);
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_word  o_out_data;
    logic       i_cfg_we;
    t_cfg_idx   i_cfg_idx;
    logic [7:0] i_cfg_data;

    i2c_word_scoreboard sb = new();

    int                   idle_pct;
    int                   stall_left;
    int                   words_sent;
    bit                   refill;
    logic [MAX_BYTES-1:0] loaded;
    // behavior of the simulated target device
    bit                   bus_held;
    int                   refuse_pct;
    logic [3:0]           nack_stages;
    bit                   refusing;

    i2c_register_master_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= idle_pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Receiver stalls
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            stall_left <= pick_gap();
            i_out_stall <= 1'b0;
        end
    end

    // Track accepted words, register writes and results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_word(o_out_data);
            if (i_cfg_we) sb.set_reg(i_cfg_idx, i_cfg_data);
            if (i_in_valid && !o_in_stall) sb.note_word(i_in_data);
        end
    end

    function automatic t_in_word rand_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_in_word)-1:0];
    endfunction

    // SDA as the target device and the bus would show it
    function automatic logic pick_sda();
        if (sb.phase == PH_START_CHK && sb.stage == ST_ADDR_W && sb.delay_count <= 1)
            return !bus_held;
        if (sb.phase == PH_ACKW_POLL) begin
            if (sb.ack_wait == 8'd0)
                refusing = nack_stages[sb.stage] || ($urandom_range(0, 99) < refuse_pct);
            if (refusing) return 1'b1;
            return ($urandom_range(0, 2) == 0);
        end
        return 1'($urandom_range(0, 1));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic put_word(input t_in_word w);
        int gap;
        gap = pick_gap();
        if ((w.kind == KIND_TICK && sb.phase != PH_IDLE) || w.kind == KIND_LOAD ||
            (w.kind == KIND_BEGIN && sb.phase == PH_IDLE))
            words_sent++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        t_in_word w;
        w = rand_word();
        w.kind = KIND_TICK;
        w.sda_sample = pick_sda();
        put_word(w);
    endtask

    task automatic load_slot(input logic [3:0] idx, input logic [7:0] val);
        t_in_word w;
        w = rand_word();
        w.kind = KIND_LOAD;
        w.byte_index = idx;
        w.write_byte = val;
        loaded[idx] = 1'b1;
        put_word(w);
    endtask

    // Stray words during a transfer: begin (ignored), load, unused kind
    task automatic send_noise();
        t_in_word w;
        w = rand_word();
        case ($urandom_range(0, 2))
            0: w.kind = KIND_BEGIN;
            1: begin
                w.kind = KIND_LOAD;
                loaded[w.byte_index] = 1'b1;
            end
            default: w.kind = KIND_UNUSED;
        endcase
        put_word(w);
    endtask

    // Sender holds off until every pending result word is out
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.expected_words.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        hold_until_drained();
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One transaction: write data loads, begin, then ticks and stray words until idle
    task automatic run_transfer(input logic rd, input logic skip, input logic [4:0] len,
                                input logic [6:0] dev, input logic [7:0] rg,
                                input bit busy_bus, input int pct, input logic [3:0] nack_at);
        t_in_word w;
        int       r;
        if (!rd) begin
            for (int n = 0; n < int'(len) && n < MAX_BYTES; n++) begin
                if (!loaded[n] || (refill && $urandom_range(0, 3) == 0))
                    load_slot(4'(n), 8'($urandom));
            end
        end
        bus_held = busy_bus;
        refuse_pct = pct;
        nack_stages = nack_at;
        refusing = 1'b0;
        w = rand_word();
        w.kind = KIND_BEGIN;
        w.device_addr = dev;
        w.reg_addr = rg;
        w.is_read = rd;
        w.skip_reg = skip;
        w.length = len;
        put_word(w);
        while (sb.phase != PH_IDLE) begin
            r = $urandom_range(0, 999);
            if (r < 30) send_noise();
            else if (r < 33) hold_until_drained();
            else send_tick();
        end
    endtask

    function automatic logic [4:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 5'($urandom_range(17, 31));
        if (r < 3) return 5'($urandom_range(5, 16));
        return 5'($urandom_range(0, 4));
    endfunction

    function automatic logic [7:0] pick_timeout();
        case ($urandom_range(0, 6))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd2;
            3: return 8'd250;
            4: return 8'd255;
            default: return 8'($urandom_range(3, 20));
        endcase
    endfunction

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int n;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_UNIT_TICKS;
        i_cfg_data = '0;
        i_out_stall = 1'b0;
        stall_left = 0;
        idle_pct = 20;
        refill = 1'b0;
        loaded = '0;
        words_sent = 0;
        bus_held = 1'b0;
        refuse_pct = 0;
        nack_stages = '0;
        refusing = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero-length write to the lowest address and register
        run_transfer(1'b0, 1'b0, 5'd0, 7'h00, 8'h00, 1'b0, 0, 4'b0);
        // bus held low at the first start
        run_transfer(1'b1, 1'b0, 5'd1, 7'h7f, 8'hff, 1'b1, 0, 4'b0);
        // write of extreme data bytes without a register byte
        load_slot(4'd0, 8'h00);
        load_slot(4'd1, 8'hff);
        load_slot(4'd2, 8'h80);
        load_slot(4'd3, 8'h7f);
        run_transfer(1'b0, 1'b1, 5'd4, 7'h55, 8'haa, 1'b0, 0, 4'b0);
        // read with repeated start
        run_transfer(1'b1, 1'b0, 5'd2, 7'h2a, 8'h0f, 1'b0, 0, 4'b0);
        // refused register byte is ignored; refused data and addresses abort
        write_reg(CFG_ACK_TIMEOUT, 8'd8);
        run_transfer(1'b0, 1'b0, 5'd2, 7'h33, 8'h12, 1'b0, 0,
                     (4'(1) << ST_REG) | (4'(1) << ST_DATA));
        run_transfer(1'b1, 1'b1, 5'd1, 7'h66, 8'h56, 1'b0, 0, 4'(1) << ST_ADDR_R);
        run_transfer(1'b0, 1'b0, 5'd1, 7'h19, 8'h78, 1'b0, 0, 4'(1) << ST_ADDR_W);
        // zero ticks per microsecond acts as one; zero timeout refuses on first high
        write_reg(CFG_UNIT_TICKS, 8'd0);
        write_reg(CFG_ACK_TIMEOUT, 8'd0);
        run_transfer(1'b0, 1'b1, 5'd0, 7'h5e, 8'hbc, 1'b0, 0, 4'b0);
        // long phases: the start check runs past 256 ticks
        write_reg(CFG_UNIT_TICKS, 8'd100);
        write_reg(CFG_ACK_TIMEOUT, 8'd250);
        run_transfer(1'b1, 1'b0, 5'd1, 7'h12, 8'hde, 1'b1, 0, 4'b0);

        // Random transfers with occasional register changes
        refill = 1'b1;
        write_reg(CFG_UNIT_TICKS, 8'd1);
        do begin
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_UNIT_TICKS, ($urandom_range(0, 7) == 0) ?
                          8'd0 : 8'($urandom_range(1, 3)));
                write_reg(CFG_ACK_TIMEOUT, pick_timeout());
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            run_transfer(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, pick_len(),
                         7'($urandom), 8'($urandom), $urandom_range(0, 14) == 0,
                         ($urandom_range(0, 9) < 7) ? 0 :
                         (($urandom_range(0, 2) == 0) ? 100 : 20),
                         ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'b0);
            repeat ($urandom_range(0, 3)) send_tick();
        end while (words_sent < 1400);

        // Wait for the last result words
        i_in_valid <= 1'b0;
        for (n = 0; n < 5000 && sb.expected_words.size() != 0; n++) @(posedge i_clk);
        if (sb.expected_words.size() != 0) begin
            $error("%0d result words never arrived", sb.expected_words.size());
            sb.errors++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
